>>> src/jksp_pkg.sv
// Shared types, constants and the hash fold for the join-key signature partitioner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jksp_pkg;

    localparam logic [63:0] FNV_BASIS     = 64'hcbf29ce484222325;
    // Prime is 2^40 + 0x1b3: fold is (t << 40) + t * 0x1b3
    localparam int          FNV_PRIME_SH  = 40;
    localparam logic [8:0]  FNV_PRIME_LO  = 9'h1b3;

    localparam int NODE_SHIFT  = 24;
    localparam int BATCH_SHIFT = 12;

    localparam int NODE_COUNT_W = 9;
    localparam int NODE_W       = 8;
    localparam int INDEX_W      = 12;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [NODE_COUNT_W-1:0] MAX_NODES = 9'd256;

    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_NODE   = 1'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [63:0] pair_sig;
        logic [63:0] fnv_sig;
        logic [31:0] row_id;
    } key_entry_t;

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [15:0] v);
        logic [63:0] t;
        logic [72:0] lo;
        t  = h ^ {48'd0, v};
        lo = 73'(t) * 73'(FNV_PRIME_LO);
        return lo[63:0] + {t[63-FNV_PRIME_SH:0], {FNV_PRIME_SH{1'b0}}};
    endfunction

endpackage

`default_nettype wire

>>> src/join_key_signature_partitioner.sv
// Top level of the join-key signature partitioner: configuration registers and wiring.
// Depends on jksp_pkg, jksp_front, jksp_queue and jksp_back.
`timescale 1ns / 1ps
`default_nettype none

// Key bytes are taken one per cycle until the queue is full; the FNV hash folds each byte
// in the cycle it arrives, and the pair hash folds each byte after the first with the one
// before it. A key's final item (last_byte or empty_key) drops a finished request into a
// two-entry queue. Behind it a bit-serial divider works out (pair ^ fnv) mod node_count;
// the back end holds each result for as long as the output register is still stalled and
// takes the next request only once that result is loaded. node_count of 0 behaves as 1
// and values above 256 as 256. Write configuration only while the block is idle.
module join_key_signature_partitioner (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_write,
    input  wire logic [jksp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [jksp_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         key_byte,
    input  wire logic                               last_byte,
    input  wire logic                               empty_key,
    input  wire logic [jksp_pkg::INDEX_W-1:0]       batch_index,
    input  wire logic [jksp_pkg::INDEX_W-1:0]       row_index,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [63:0]                             pair_signature,
    output logic [63:0]                             fnv_signature,
    output logic [jksp_pkg::NODE_W-1:0]             target_node,
    output logic [31:0]                             packed_row_id
);

    logic [jksp_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic [jksp_pkg::NODE_W-1:0]       own_node_reg;

    logic                  accept;
    logic                  push;
    jksp_pkg::key_entry_t  push_entry;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  q_pop;
    jksp_pkg::key_entry_t  q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= jksp_pkg::NODE_COUNT_W'(1);
            own_node_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                jksp_pkg::REG_NODE_COUNT:
                begin
                    node_count_reg <= cfg_data[jksp_pkg::NODE_COUNT_W-1:0];
                end
                jksp_pkg::REG_OWN_NODE:
                begin
                    own_node_reg <= cfg_data[jksp_pkg::NODE_W-1:0];
                end
                default:
                begin
                    node_count_reg <= node_count_reg;
                end
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    jksp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .key_byte    (key_byte),
        .last_byte   (last_byte),
        .empty_key   (empty_key),
        .batch_index (batch_index),
        .row_index   (row_index),
        .own_node    (own_node_reg),
        .push        (push),
        .entry       (push_entry)
    );

    jksp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    jksp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .node_count     (node_count_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pair_signature (pair_signature),
        .fnv_signature  (fnv_signature),
        .target_node    (target_node),
        .packed_row_id  (packed_row_id)
    );

endmodule

`default_nettype wire

>>> src/jksp_front.sv
// Front end: folds key bytes into the two running hashes and builds one entry per key.
// Depends on jksp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jksp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [7:0]                    key_byte,
    input  wire logic                          last_byte,
    input  wire logic                          empty_key,
    input  wire logic [jksp_pkg::INDEX_W-1:0]  batch_index,
    input  wire logic [jksp_pkg::INDEX_W-1:0]  row_index,
    input  wire logic [jksp_pkg::NODE_W-1:0]   own_node,
    output logic                               push,
    output jksp_pkg::key_entry_t               entry
);

    logic [63:0] fnv_reg, fnv_next;
    logic [63:0] pair_reg, pair_next;
    logic [7:0]  prev_reg, prev_next;
    logic        seen_reg, seen_next;

    logic [63:0] fnv_fold_w;
    logic [63:0] pair_fold_w;
    logic        final_w;

    always_comb
    begin
        fnv_fold_w = jksp_pkg::fnv_fold(fnv_reg, {8'd0, key_byte});
        if (seen_reg)
        begin
            pair_fold_w = jksp_pkg::fnv_fold(pair_reg, {prev_reg, key_byte});
        end
        else if (last_byte)
        begin
            pair_fold_w = jksp_pkg::fnv_fold(pair_reg, {8'd0, key_byte});
        end
        else
        begin
            pair_fold_w = pair_reg;
        end

        final_w = empty_key || last_byte;

        entry.row_id = (32'(own_node) << jksp_pkg::NODE_SHIFT)
                     | (32'(batch_index) << jksp_pkg::BATCH_SHIFT)
                     | 32'(row_index);
        if (empty_key)
        begin
            entry.pair_sig = jksp_pkg::FNV_BASIS;
            entry.fnv_sig  = jksp_pkg::FNV_BASIS;
        end
        else
        begin
            entry.pair_sig = pair_fold_w;
            entry.fnv_sig  = fnv_fold_w;
        end
        push = accept && final_w;

        fnv_next  = fnv_reg;
        pair_next = pair_reg;
        prev_next = prev_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (final_w)
            begin
                fnv_next  = jksp_pkg::FNV_BASIS;
                pair_next = jksp_pkg::FNV_BASIS;
                prev_next = 8'd0;
                seen_next = 1'b0;
            end
            else
            begin
                fnv_next  = fnv_fold_w;
                pair_next = pair_fold_w;
                prev_next = key_byte;
                seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fnv_reg  <= jksp_pkg::FNV_BASIS;
            pair_reg <= jksp_pkg::FNV_BASIS;
            prev_reg <= 8'd0;
            seen_reg <= 1'b0;
        end
        else
        begin
            fnv_reg  <= fnv_next;
            pair_reg <= pair_next;
            prev_reg <= prev_next;
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

>>> src/jksp_queue.sv
// Short queue of finished key entries between front and back ends.
// Depends on jksp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jksp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire jksp_pkg::key_entry_t  push_entry,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       not_empty,
    output jksp_pkg::key_entry_t       head
);

    jksp_pkg::key_entry_t mem_reg [jksp_pkg::QUEUE_DEPTH];

    logic [jksp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jksp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jksp_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                             do_pop;

    always_comb
    begin
        full      = (count_reg == jksp_pkg::QUEUE_CNT_W'(jksp_pkg::QUEUE_DEPTH));
        not_empty = (count_reg != '0);
        head      = mem_reg[rd_ptr_reg];
        do_pop    = pop && not_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == jksp_pkg::QUEUE_PTR_W'(jksp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == jksp_pkg::QUEUE_PTR_W'(jksp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= jksp_pkg::QUEUE_CNT_W'(jksp_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("request pushed into full queue");

endmodule

`default_nettype wire

>>> src/jksp_back.sv
// Back end: bit-serial modulo of the signature XOR by the node count, and output register.
// Depends on jksp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jksp_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_not_empty,
    input  wire jksp_pkg::key_entry_t               q_head,
    output logic                                    q_pop,
    input  wire logic [jksp_pkg::NODE_COUNT_W-1:0]  node_count,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [63:0]                             pair_signature,
    output logic [63:0]                             fnv_signature,
    output logic [jksp_pkg::NODE_W-1:0]             target_node,
    output logic [31:0]                             packed_row_id
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } back_state_t;

    back_state_t                        state_reg, state_next;
    jksp_pkg::key_entry_t               work_reg, work_next;
    logic [63:0]                        dividend_reg, dividend_next;
    logic [jksp_pkg::NODE_W-1:0]        rem_reg, rem_next;
    logic [jksp_pkg::NODE_COUNT_W-1:0]  divisor_reg, divisor_next;
    logic [jksp_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;
    jksp_pkg::key_entry_t               out_reg, out_next;
    logic [jksp_pkg::NODE_W-1:0]        node_reg, node_next;

    logic [jksp_pkg::NODE_COUNT_W-1:0]  n_clamped;
    logic [jksp_pkg::NODE_COUNT_W-1:0]  trial;
    logic [jksp_pkg::NODE_COUNT_W-1:0]  trial_sub;
    logic                               out_free;

    always_comb
    begin
        if (node_count == '0)
        begin
            n_clamped = jksp_pkg::NODE_COUNT_W'(1);
        end
        else if (node_count > jksp_pkg::MAX_NODES)
        begin
            n_clamped = jksp_pkg::MAX_NODES;
        end
        else
        begin
            n_clamped = node_count;
        end

        trial     = {rem_reg, dividend_reg[63]};
        trial_sub = trial - divisor_reg;
        out_free  = !out_valid_reg || !out_stall;

        state_next     = state_reg;
        work_next      = work_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        node_next      = node_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop         = 1'b1;
                    work_next     = q_head;
                    dividend_next = q_head.pair_sig ^ q_head.fnv_sig;
                    rem_next      = '0;
                    divisor_next  = n_clamped;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= divisor_reg)
                begin
                    rem_next = trial_sub[jksp_pkg::NODE_W-1:0];
                end
                else
                begin
                    rem_next = trial[jksp_pkg::NODE_W-1:0];
                end
                dividend_next = {dividend_reg[62:0], 1'b0};
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == jksp_pkg::DIV_CNT_W'(jksp_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = work_reg;
                    node_next      = rem_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            work_reg      <= '0;
            dividend_reg  <= '0;
            rem_reg       <= '0;
            divisor_reg   <= jksp_pkg::NODE_COUNT_W'(1);
            out_reg       <= '0;
            node_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            work_reg      <= work_next;
            dividend_reg  <= dividend_next;
            rem_reg       <= rem_next;
            divisor_reg   <= divisor_next;
            out_reg       <= out_next;
            node_reg      <= node_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pair_signature = out_reg.pair_sig;
    assign fnv_signature  = out_reg.fnv_sig;
    assign packed_row_id  = out_reg.row_id;
    assign target_node    = node_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (jksp_pkg::NODE_COUNT_W'(rem_reg) < divisor_reg))
        else $error("remainder not below divisor");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == jksp_pkg::DIV_CNT_W'(jksp_pkg::DIV_STEPS - 1))
        |=> (state_reg == ST_DONE))
        else $error("division did not finish after last step");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for join_key_signature_partitioner: directed and random key
// streams are checked against an in-bench model of both hashes, node choice and row id.
// Depends on jksp_pkg and the RTL under src.
`timescale 1ns / 1ps

module testbench;

    localparam logic [63:0] KEY_BASIS   = 64'hcbf29ce484222325;
    localparam logic [63:0] KEY_PRIME   = 64'h00000100000001b3;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 150;
    localparam int          PHASE_ITEMS = 435;

    typedef struct {
        logic [63:0] pair_sig;
        logic [63:0] fnv_sig;
        logic [7:0]  node;
        logic [31:0] row_id;
    } signature_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [jksp_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [jksp_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [7:0]                        key_byte;
    logic                              last_byte;
    logic                              empty_key;
    logic [jksp_pkg::INDEX_W-1:0]      batch_index;
    logic [jksp_pkg::INDEX_W-1:0]      row_index;
    logic                              out_valid;
    logic                              out_stall;
    logic [63:0]                       pair_signature;
    logic [63:0]                       fnv_signature;
    logic [jksp_pkg::NODE_W-1:0]       target_node;
    logic [31:0]                       packed_row_id;

    // predictor state and register copies
    logic [63:0]             model_fnv;
    logic [63:0]             model_pair;
    logic [7:0]              model_prev;
    logic                    model_have_byte;
    logic [8:0]              model_node_count;
    logic [7:0]              model_own_node;

    signature_t              pending_signatures[$];
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      error_count;
    int                      cycle_count;

    join_key_signature_partitioner dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_byte       (key_byte),
        .last_byte      (last_byte),
        .empty_key      (empty_key),
        .batch_index    (batch_index),
        .row_index      (row_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pair_signature (pair_signature),
        .fnv_signature  (fnv_signature),
        .target_node    (target_node),
        .packed_row_id  (packed_row_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [63:0] v);
        hash_step = (h ^ v) * KEY_PRIME;
    endfunction

    task automatic clear_key_model();
        model_fnv       = KEY_BASIS;
        model_pair      = KEY_BASIS;
        model_prev      = 8'd0;
        model_have_byte = 1'b0;
    endtask

    task automatic predict_signature(input logic [7:0] b, input logic last, input logic empty,
                                     input logic [11:0] batch, input logic [11:0] row);
        signature_t  s;
        logic [8:0]  n;
        logic        done;
        done = 1'b1;
        if (empty)
        begin
            s.pair_sig = KEY_BASIS;
            s.fnv_sig  = KEY_BASIS;
        end
        else
        begin
            model_fnv = hash_step(model_fnv, {56'd0, b});
            if (model_have_byte)
                model_pair = hash_step(model_pair, {48'd0, model_prev, b});
            else if (last)
                model_pair = hash_step(model_pair, {56'd0, b});
            model_prev      = b;
            model_have_byte = 1'b1;
            done            = last;
            s.pair_sig      = model_pair;
            s.fnv_sig       = model_fnv;
        end
        if (done)
        begin
            n = model_node_count;
            if (n == 9'd0)
                n = 9'd1;
            if (n > 9'd256)
                n = 9'd256;
            s.node   = 8'((s.pair_sig ^ s.fnv_sig) % {55'd0, n});
            s.row_id = {model_own_node, batch, row};
            pending_signatures.insert(pending_signatures.size(), s);
            clear_key_model();
        end
    endtask

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input logic [7:0] b, input logic last, input logic empty,
                             input logic [11:0] batch, input logic [11:0] row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        key_byte    <= b;
        last_byte   <= last;
        empty_key   <= empty;
        batch_index <= batch;
        row_index   <= row;
        predict_signature(b, last, empty, batch, row);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_key(input int len);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), i == len - 1, 1'b0, 12'($urandom), 12'($urandom));
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_signatures.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input logic [jksp_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [jksp_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == jksp_pkg::REG_NODE_COUNT)
            model_node_count = data;
        else
            model_own_node = data[7:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t %s expected %h got %h", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        signature_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_signatures.size() == 0)
            begin
                $display("%0t unrequested result: expected none got %h %h %h %h", $time,
                         pair_signature, fnv_signature, target_node, packed_row_id);
                error_count++;
            end
            else
            begin
                e = pending_signatures.pop_front();
                report_field("pair_signature", e.pair_sig, pair_signature);
                report_field("fnv_signature", e.fnv_sig, fnv_signature);
                report_field("target_node", {56'd0, e.node}, {56'd0, target_node});
                report_field("packed_row_id", {32'd0, e.row_id}, {32'd0, packed_row_id});
            end
        end
    end

    task automatic test_single_byte_keys();
        send_item(8'h00, 1'b1, 1'b0, 12'h000, 12'hfff);
        send_item(8'hff, 1'b1, 1'b0, 12'hfff, 12'hfff);
    endtask

    task automatic test_empty_keys();
        send_item(8'haa, 1'b0, 1'b1, 12'h123, 12'h456);
        send_item(8'h55, 1'b1, 1'b1, 12'h000, 12'h000);
    endtask

    task automatic test_empty_mid_key();
        send_item(8'h41, 1'b0, 1'b0, 12'h001, 12'h002);
        send_item(8'h42, 1'b0, 1'b0, 12'h003, 12'h004);
        send_item(8'h43, 1'b0, 1'b0, 12'h005, 12'h006);
        send_item(8'h00, 1'b0, 1'b1, 12'hfff, 12'h000);
        send_item(8'h12, 1'b0, 1'b0, 12'h000, 12'h000);
        send_item(8'h34, 1'b1, 1'b0, 12'h800, 12'h801);
    endtask

    task automatic test_node_count_limits();
        settle_block();
        write_register(jksp_pkg::REG_NODE_COUNT, 9'd0);
        write_register(jksp_pkg::REG_OWN_NODE, 9'h1ff);
        send_item(8'hff, 1'b0, 1'b0, 12'h000, 12'h000);
        send_item(8'hff, 1'b1, 1'b0, 12'hfff, 12'h000);
        settle_block();
        write_register(jksp_pkg::REG_NODE_COUNT, 9'd256);
        send_key(3);
        settle_block();
        write_register(jksp_pkg::REG_NODE_COUNT, 9'h1ff);
        send_key(1);
        settle_block();
        write_register(jksp_pkg::REG_NODE_COUNT, 9'd7);
        write_register(jksp_pkg::REG_OWN_NODE, 9'h000);
        send_key(2);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        logic [8:0] counts[8];
        int         sent;
        int         kind;
        int         len;
        counts = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'h1ff, 9'd3};
        settle_block();
        if ($urandom_range(1))
            write_register(jksp_pkg::REG_NODE_COUNT, counts[$urandom_range(7)]);
        else
            write_register(jksp_pkg::REG_NODE_COUNT, 9'($urandom));
        write_register(jksp_pkg::REG_OWN_NODE, 9'($urandom));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            kind = $urandom_range(99);
            len  = (kind < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            if (kind < 7)
            begin
                send_item(8'($urandom), 1'($urandom), 1'b1, 12'($urandom), 12'($urandom));
                sent++;
            end
            else if (kind < 14)
            begin
                // key cut short by an empty-key request
                for (int i = 0; i < len; i++)
                    send_item(8'($urandom), 1'b0, 1'b0, 12'($urandom), 12'($urandom));
                send_item(8'($urandom), 1'($urandom), 1'b1, 12'($urandom), 12'($urandom));
                sent += len + 1;
            end
            else
            begin
                send_key(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = jksp_pkg::REG_NODE_COUNT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        key_byte       = 8'd0;
        last_byte      = 1'b0;
        empty_key      = 1'b0;
        batch_index    = '0;
        row_index      = '0;
        out_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        model_node_count = 9'd1;
        model_own_node   = 8'd0;
        clear_key_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_byte_keys();
        test_empty_keys();
        test_empty_mid_key();
        test_node_count_limits();
        test_random_traffic(0, 0);
        test_random_traffic(87, 0);
        test_random_traffic(0, 87);
        test_random_traffic(8, 8);

        settle_block();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> join_key_signature_partitioner.f
src/jksp_pkg.sv
src/jksp_front.sv
src/jksp_queue.sv
src/jksp_back.sv
src/join_key_signature_partitioner.sv
sim/testbench.sv
